/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the printer transmit framer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PTX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define PTX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/core/ptx_pkg.sv */
// ----------------------------------------------------------------------------
// ptx_pkg
// Types and constants shared by the printer transmit framer modules.
// ----------------------------------------------------------------------------
package ptx_pkg;

  // Byte store geometry. The depth is a power of two.
  localparam int STORE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths.
  localparam int BYTE_W      = 8;
  localparam int LOAD_ADDR_W = 10;
  localparam int POS_W       = 11;
  localparam int LEN_W       = 11;
  localparam int START_W     = 10;
  localparam int COL_W       = 8;
  localparam int HDR_W       = 3;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  // Input item kinds.
  typedef enum logic [1:0] {
    KIND_LOAD     = 2'd0,
    KIND_TX_READY = 2'd1,
    KIND_CTS_POLL = 2'd2,
    KIND_START    = 2'd3
  } kind_t;

  // Transmit modes. Code 3 is unused.
  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BLOCK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RASTER = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 2'd3;

  // Row header phases.
  localparam logic [HDR_W-1:0] HDR_ESC  = 3'd0;
  localparam logic [HDR_W-1:0] HDR_W_CH = 3'd1;
  localparam logic [HDR_W-1:0] HDR_LEN  = 3'd2;
  localparam logic [HDR_W-1:0] HDR_ZERO = 3'd3;
  localparam logic [HDR_W-1:0] HDR_DATA = 3'd4;

  // Row header bytes.
  localparam logic [BYTE_W-1:0] ESC_CODE = 8'h1b;
  localparam logic [BYTE_W-1:0] W_CODE   = 8'h57;

  // Input item as seen by the sequencer.
  typedef struct packed {
    kind_t                  kind;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [BYTE_W-1:0]      load_data;
    logic                   cts_busy;
  } item_t;

  // Configuration write.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Store access issued by the sequencer.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Result under construction, waiting for the store read data.
  typedef struct packed {
    logic              tx_valid;
    logic              from_store;
    logic [BYTE_W-1:0] const_byte;
    logic              flow_stopped;
    logic              waiting;
  } pend_t;

endpackage

/* rtl/core/ptx_if.sv */
// ----------------------------------------------------------------------------
// ptx channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ptx_item_if;
  logic                            valid;
  logic                            ready;
  ptx_pkg::kind_t                  kind;
  logic [ptx_pkg::LOAD_ADDR_W-1:0] load_address;
  logic [ptx_pkg::BYTE_W-1:0]      load_data;
  logic                            cts_busy;

  modport source (output valid, kind, load_address, load_data, cts_busy, input ready);
  modport sink   (input valid, kind, load_address, load_data, cts_busy, output ready);
endinterface

interface ptx_result_if;
  logic                       valid;
  logic                       ready;
  logic                       tx_valid;
  logic [ptx_pkg::BYTE_W-1:0] tx_byte;
  logic                       flow_stopped;
  logic                       waiting;

  modport source (output valid, tx_valid, tx_byte, flow_stopped, waiting, input ready);
  modport sink   (input valid, tx_valid, tx_byte, flow_stopped, waiting, output ready);
endinterface

interface ptx_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ptx_pkg::CFG_IDX_W-1:0]  index;
  logic [ptx_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/ptx_ram.sv */
// ----------------------------------------------------------------------------
// ptx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ptx_seq.sv */
// ----------------------------------------------------------------------------
// ptx_seq
// Job state, configuration registers and the per-item send decision.
// ----------------------------------------------------------------------------
module ptx_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  ptx_pkg::item_t   item,
  input  ptx_pkg::cfg_wr_t cfg_wr,
  output ptx_pkg::mem_req_t mem_req,
  output ptx_pkg::pend_t   pend
);
  import ptx_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0]  mode;
  logic [LEN_W-1:0]   length;
  logic [START_W-1:0] start_address;
  logic [COL_W-1:0]   row_bytes;

  // Job state and next values.
  logic [POS_W-1:0]  position, position_next;
  logic [ADDR_W-1:0] read_pointer, read_pointer_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [HDR_W-1:0]  header_phase, header_phase_next;
  logic [COL_W-1:0]  column_pos, column_pos_next;
  logic              not_ready, not_ready_next;
  logic              block_active, block_active_next;

  logic              do_send;
  logic [COL_W-1:0]  col_inc;
  logic [ADDR_W-1:0] raddr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_PLAIN;
      length        <= '0;
      start_address <= '0;
      row_bytes     <= COL_W'(1);
    end else if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        REG_MODE:      mode          <= cfg_wr.data[MODE_W-1:0];
        REG_LENGTH:    length        <= cfg_wr.data[LEN_W-1:0];
        REG_START:     start_address <= cfg_wr.data[START_W-1:0];
        REG_ROW_BYTES: row_bytes     <= cfg_wr.data[COL_W-1:0];
        default:       ;
      endcase
    end
  end

  // Column counter wraps at 256 and restarts at the row width.
  assign col_inc = column_pos + COL_W'(1);

  // Next state and result decision for one item.
  always_comb begin
    position_next     = position;
    read_pointer_next = read_pointer;
    remaining_next    = remaining;
    header_phase_next = header_phase;
    column_pos_next   = column_pos;
    not_ready_next    = not_ready;
    block_active_next = block_active;
    raddr             = read_pointer;
    do_send           = 1'b0;
    pend              = '0;

    case (item.kind)
      KIND_TX_READY: begin
        if (item.cts_busy) begin
          not_ready_next    = 1'b1;
          pend.flow_stopped = 1'b1;
        end else begin
          do_send = 1'b1;
        end
      end
      KIND_CTS_POLL: begin
        if (not_ready && !item.cts_busy) begin
          not_ready_next = 1'b0;
          do_send        = 1'b1;
        end
      end
      KIND_START: begin
        position_next     = '0;
        column_pos_next   = '0;
        header_phase_next = HDR_ESC;
        read_pointer_next = ADDR_W'(start_address);
        remaining_next    = length;
        block_active_next = 1'b1;
      end
      default: ;
    endcase

    if (do_send) begin
      case (mode)
        MODE_PLAIN: begin
          if (position < length) begin
            pend.tx_valid   = 1'b1;
            pend.from_store = 1'b1;
            raddr           = ADDR_W'(position);
            position_next   = position + POS_W'(1);
          end
        end
        MODE_BLOCK: begin
          if (block_active) begin
            if (remaining != '0) begin
              pend.tx_valid     = 1'b1;
              pend.from_store   = 1'b1;
              read_pointer_next = read_pointer + ADDR_W'(1);
              remaining_next    = remaining - LEN_W'(1);
            end else begin
              block_active_next = 1'b0;
            end
          end
        end
        MODE_RASTER: begin
          // Row header comes first at every row start.
          if (column_pos == '0 && header_phase != HDR_DATA) begin
            case (header_phase)
              HDR_ESC: begin
                if (position < length) begin
                  pend.tx_valid     = 1'b1;
                  pend.const_byte   = ESC_CODE;
                  header_phase_next = HDR_W_CH;
                end
              end
              HDR_W_CH: begin
                pend.tx_valid     = 1'b1;
                pend.const_byte   = W_CODE;
                header_phase_next = HDR_LEN;
              end
              HDR_LEN: begin
                pend.tx_valid     = 1'b1;
                pend.const_byte   = row_bytes;
                header_phase_next = HDR_ZERO;
              end
              HDR_ZERO: begin
                pend.tx_valid     = 1'b1;
                pend.const_byte   = '0;
                header_phase_next = HDR_DATA;
              end
              default: begin
                // Phases past the header behave as the first image byte.
                pend.tx_valid     = 1'b1;
                pend.from_store   = 1'b1;
                header_phase_next = HDR_ESC;
                read_pointer_next = read_pointer + ADDR_W'(1);
                position_next     = position + POS_W'(1);
                column_pos_next   = (col_inc == row_bytes) ? '0 : col_inc;
              end
            endcase
          end else begin
            // Image byte; the first byte of a row also closes the header.
            pend.tx_valid     = 1'b1;
            pend.from_store   = 1'b1;
            if (column_pos == '0) begin
              header_phase_next = HDR_ESC;
            end
            read_pointer_next = read_pointer + ADDR_W'(1);
            position_next     = position + POS_W'(1);
            column_pos_next   = (col_inc == row_bytes) ? '0 : col_inc;
          end
        end
        default: ;
      endcase
    end

    pend.waiting = not_ready_next;
  end

  // Store access for this item.
  always_comb begin
    mem_req.we    = accept && (item.kind == KIND_LOAD);
    mem_req.waddr = ADDR_W'(item.load_address);
    mem_req.wdata = item.load_data;
    mem_req.re    = accept;
    mem_req.raddr = raddr;
  end

  // Job state update on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= '0;
      read_pointer <= '0;
      remaining    <= '0;
      header_phase <= HDR_ESC;
      column_pos   <= '0;
      not_ready    <= 1'b0;
      block_active <= 1'b0;
    end else if (accept) begin
      position     <= position_next;
      read_pointer <= read_pointer_next;
      remaining    <= remaining_next;
      header_phase <= header_phase_next;
      column_pos   <= column_pos_next;
      not_ready    <= not_ready_next;
      block_active <= block_active_next;
    end
  end

endmodule

/* rtl/core/ptx_out.sv */
// ----------------------------------------------------------------------------
// ptx_out
// Read stage that merges store data into the result, and the output register.
// ----------------------------------------------------------------------------
module ptx_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  ptx_pkg::pend_t             pend,
  input  logic [ptx_pkg::BYTE_W-1:0] rdata,
  output logic                       free,
  ptx_result_if.source               result
);
  import ptx_pkg::*;

  logic  s1_valid;
  pend_t s1_pend;
  logic  s1_adv;

  // The read stage moves on when the output register is empty or drains.
  assign s1_adv = s1_valid && (!result.valid || result.ready);
  assign free   = !s1_valid || s1_adv;

  // Read stage: holds the item while the registered store read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pend <= pend;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.tx_valid     <= s1_pend.tx_valid;
      result.flow_stopped <= s1_pend.flow_stopped;
      result.waiting      <= s1_pend.waiting;
      if (!s1_pend.tx_valid) begin
        result.tx_byte <= '0;
      end else if (s1_pend.from_store) begin
        result.tx_byte <= rdata;
      end else begin
        result.tx_byte <= s1_pend.const_byte;
      end
    end
  end

endmodule

/* rtl/core/printer_tx_framer_with_cts_unit.sv */
// ----------------------------------------------------------------------------
// printer_tx_framer_with_cts_unit
// Printer serial transmit framer with CTS flow control and raster row headers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  item     in         kind, load_address, load_data, cts_busy
//  result   out        tx_valid, tx_byte, flow_stopped, waiting
//  cfg      in         index, data (mode, length, start_address, row_bytes)
//
// One item is taken per cycle while item ready is high; its result passes the
// read stage, for the registered store read, and then the output register.
// Reset clears the job state and registers; the byte store is not cleared.
// A stall on the result side holds the read stage, and the item channel
// stops only once both the read stage and the output register are full.
// The configuration channel is always ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module printer_tx_framer_with_cts_unit (
  input logic        clk,
  input logic        rst,
  ptx_item_if.sink   item,
  ptx_result_if.source result,
  ptx_cfg_if.sink    cfg
);
  import ptx_pkg::*;

  logic                 accept;
  logic                 free;
  item_t                item_q;
  cfg_wr_t              cfg_wr;
  mem_req_t             mem_req;
  pend_t                pend;
  logic [BYTE_W-1:0]    rdata;

  // Handshakes.
  assign item.ready = free;
  assign accept     = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // Bundle the channel payloads.
  always_comb begin
    item_q.kind         = item.kind;
    item_q.load_address = item.load_address;
    item_q.load_data    = item.load_data;
    item_q.cts_busy     = item.cts_busy;
    cfg_wr.we           = cfg.valid && cfg.ready;
    cfg_wr.index        = cfg.index;
    cfg_wr.data         = cfg.data;
  end

  ptx_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item_q),
    .cfg_wr  (cfg_wr),
    .mem_req (mem_req),
    .pend    (pend)
  );

  ptx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rdata)
  );

  ptx_out u_out (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .pend   (pend),
    .rdata  (rdata),
    .free   (free),
    .result (result)
  );

  // Every transfer shows up on the result side through the read stage and the output register.
  `PTX_ASSERT(a_result_latency, accept |-> ##2 result.valid, "result missing after transfer")
  // A busy CTS never goes together with a sent byte.
  `PTX_ASSERT(a_stop_no_tx, result.valid && result.flow_stopped |-> !result.tx_valid && result.waiting, "stop with byte")
  // No byte means a zero byte.
  `PTX_ASSERT(a_idle_byte, result.valid && !result.tx_valid |-> result.tx_byte == '0, "nonzero idle byte")
  // Reset empties the output register.
  `PTX_ASSERT_ALWAYS(a_reset_empty, rst |=> !result.valid, "result valid after reset")

endmodule

/* tb/tx_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tx_frame_checker
// Watches the item, result and configuration channels of the printer transmit
// framer, keeps its own copy of the job state and the byte store, works out
// the result of every accepted item and compares each result transfer with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tx_frame_checker (
  input  logic  clk,
  input  logic  rst,
  ptx_item_if   item_ch,
  ptx_result_if result_ch,
  ptx_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending_count,
  output int    bytes_framed
);
  import ptx_pkg::*;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    logic              flow_stopped;
    logic              waiting;
  } tx_out_t;

  // Copies of the configuration registers.
  logic [MODE_W-1:0]  reg_mode;
  logic [LEN_W-1:0]   reg_length;
  logic [START_W-1:0] reg_start;
  logic [BYTE_W-1:0]  reg_row_bytes;

  // Job state as the framer should hold it.
  logic [BYTE_W-1:0] shadow_store [STORE_DEPTH];
  logic [POS_W-1:0]  job_pos;
  logic [ADDR_W-1:0] job_rd_ptr;
  logic [LEN_W-1:0]  job_left;
  logic [HDR_W-1:0]  job_hdr;
  logic [COL_W-1:0]  job_col;
  logic              printer_busy;
  logic              job_active;

  // Predicted results, oldest first.
  tx_out_t awaited_out [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // Works out the byte a clear transmitter-ready event or CTS resume hands out, if any.
  task automatic next_job_byte(output logic sent, output logic [BYTE_W-1:0] b);
    logic             from_store;
    logic [COL_W-1:0] col_next;
    sent       = 1'b0;
    b          = '0;
    from_store = 1'b0;
    case (reg_mode)
      MODE_PLAIN: begin
        if (job_pos < reg_length) begin
          b       = shadow_store[job_pos[ADDR_W-1:0]];
          job_pos = job_pos + 1'b1;
          sent    = 1'b1;
        end
      end
      MODE_BLOCK: begin
        // An exhausted count ends the job until the next start.
        if (job_active) begin
          if (job_left != '0) begin
            from_store = 1'b1;
            job_left   = job_left - 1'b1;
          end else begin
            job_active = 1'b0;
          end
        end
      end
      MODE_RASTER: begin
        from_store = 1'b1;
        // A row opens with its four-byte header; a finished image sends nothing.
        if (job_col == '0) begin
          from_store = 1'b0;
          sent       = 1'b1;
          case (job_hdr)
            HDR_ESC: begin
              if (job_pos < reg_length) begin
                b       = ESC_CODE;
                job_hdr = HDR_W_CH;
              end else begin
                sent = 1'b0;
              end
            end
            HDR_W_CH: begin
              b       = W_CODE;
              job_hdr = HDR_LEN;
            end
            HDR_LEN: begin
              b       = reg_row_bytes;
              job_hdr = HDR_ZERO;
            end
            HDR_ZERO: begin
              b       = '0;
              job_hdr = HDR_DATA;
            end
            default: begin
              job_hdr    = HDR_ESC;
              sent       = 1'b0;
              from_store = 1'b1;
            end
          endcase
        end
        // Image bytes run to the end of the row whatever the length says.
        if (from_store) begin
          job_pos  = job_pos + 1'b1;
          col_next = job_col + 1'b1;
          job_col  = (col_next == reg_row_bytes) ? '0 : col_next;
        end
      end
      default: ;
    endcase
    if (from_store) begin
      b          = shadow_store[job_rd_ptr];
      job_rd_ptr = job_rd_ptr + 1'b1;
      sent       = 1'b1;
    end
  endtask

  // Applies one accepted item to the state and returns its result.
  task automatic frame_item(input kind_t kind, input logic [ADDR_W-1:0] addr,
                            input logic [BYTE_W-1:0] data, input logic busy,
                            output tx_out_t res);
    logic              sent;
    logic [BYTE_W-1:0] b;
    sent = 1'b0;
    b    = '0;
    res  = '0;
    case (kind)
      KIND_LOAD: shadow_store[addr] = data;
      KIND_TX_READY: begin
        if (busy) begin
          printer_busy     = 1'b1;
          res.flow_stopped = 1'b1;
        end else begin
          next_job_byte(sent, b);
        end
      end
      KIND_CTS_POLL: begin
        if (printer_busy && !busy) begin
          printer_busy = 1'b0;
          next_job_byte(sent, b);
        end
      end
      default: begin
        job_pos    = '0;
        job_col    = '0;
        job_hdr    = HDR_ESC;
        job_rd_ptr = reg_start;
        job_left   = reg_length;
        job_active = 1'b1;
      end
    endcase
    res.tx_valid = sent;
    res.tx_byte  = sent ? b : '0;
    res.waiting  = printer_busy;
  endtask

  task automatic compare_result(input tx_out_t seen, input tx_out_t want);
    if (seen.tx_valid !== want.tx_valid)
      report_mismatch($sformatf("tx_valid is %0b, expected %0b", seen.tx_valid, want.tx_valid));
    if (seen.tx_byte !== want.tx_byte)
      report_mismatch($sformatf("tx_byte is %02h, expected %02h", seen.tx_byte, want.tx_byte));
    if (seen.flow_stopped !== want.flow_stopped)
      report_mismatch($sformatf("flow_stopped is %0b, expected %0b",
                                seen.flow_stopped, want.flow_stopped));
    if (seen.waiting !== want.waiting)
      report_mismatch($sformatf("waiting is %0b, expected %0b", seen.waiting, want.waiting));
  endtask

  // All three channels are sampled at the rising edge.
  always @(posedge clk) begin : watch
    tx_out_t seen;
    tx_out_t want;
    if (rst) begin
      reg_mode      = MODE_PLAIN;
      reg_length    = '0;
      reg_start     = '0;
      reg_row_bytes = 8'd1;
      job_pos       = '0;
      job_rd_ptr    = '0;
      job_left      = '0;
      job_hdr       = HDR_ESC;
      job_col       = '0;
      printer_busy  = 1'b0;
      job_active    = 1'b0;
      awaited_out.delete();
      fail_count    = 0;
      pending_count = 0;
      bytes_framed  = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_MODE:   reg_mode   = cfg_ch.data[MODE_W-1:0];
          REG_LENGTH: reg_length = cfg_ch.data[LEN_W-1:0];
          REG_START:  reg_start  = cfg_ch.data[START_W-1:0];
          default:    reg_row_bytes = cfg_ch.data[BYTE_W-1:0];
        endcase
      end
      // A result belongs to an earlier item, so it is matched before this
      // edge's item is predicted.
      if (result_ch.valid && result_ch.ready) begin
        seen.tx_valid     = result_ch.tx_valid;
        seen.tx_byte      = result_ch.tx_byte;
        seen.flow_stopped = result_ch.flow_stopped;
        seen.waiting      = result_ch.waiting;
        if (awaited_out.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = awaited_out.pop_front();
          compare_result(seen, want);
        end
        if (seen.tx_valid === 1'b1) bytes_framed++;
      end
      if (item_ch.valid && item_ch.ready) begin
        frame_item(item_ch.kind, item_ch.load_address, item_ch.load_data,
                   item_ch.cts_busy, want);
        awaited_out.push_back(want);
      end
      pending_count = awaited_out.size();
    end
  end

endmodule

/* tb/tb_printer_tx_framer_with_cts_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_printer_tx_framer_with_cts_unit
// Drives the printer transmit framer with store loads, job starts,
// transmitter-ready events and CTS polls under random flow control in all
// three modes and the unused one, and takes its verdict from the checker.
// ----------------------------------------------------------------------------
module tb_printer_tx_framer_with_cts_unit;
  import ptx_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 400;
  localparam int CALM_ITEMS     = 80;
  localparam int HOLD_PHASE     = 2;
  localparam int LONG_HOLD      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // Mode code that has no behavior of its own.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst;

  ptx_item_if   item_ch ();
  ptx_result_if result_ch ();
  ptx_cfg_if    cfg_ch ();

  int fail_count;
  int pending_count;
  int bytes_framed;

  int items_sent  = 0;
  int calm_mark   = 32'h7fff_ffff;
  int idle_cycles = 0;
  bit calm         = 1'b0;
  bit quiet_phase  = 1'b0;
  bit hold_off_req = 1'b0;
  bit hold_done    = 1'b0;
  bit stored_addr [STORE_DEPTH];

  always #(CLK_PERIOD / 2) clk = ~clk;

  printer_tx_framer_with_cts_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  tx_frame_checker frame_check (
    .clk           (clk),
    .rst           (rst),
    .item_ch       (item_ch),
    .result_ch     (result_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .bytes_framed  (bytes_framed)
  );

  // Offers one item, maybe after a short gap, and returns after its transfer.
  task automatic send_item(input kind_t k, input logic [ADDR_W-1:0] addr,
                           input logic [BYTE_W-1:0] data, input logic busy);
    int gap;
    if (!calm && !quiet_phase && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= k;
    item_ch.load_address <= addr;
    item_ch.load_data    <= data;
    item_ch.cts_busy     <= busy;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    if (k == KIND_LOAD) stored_addr[addr] = 1'b1;
    if (items_sent >= calm_mark) calm = 1'b1;
  endtask

  // Sends an item whose unused fields carry random values.
  task automatic send_event(input kind_t k, input logic busy);
    send_item(k, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)), BYTE_W'($urandom_range(0, 255)),
              busy);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Reprograms all four registers while the framer is idle.
  task automatic set_job(input logic [MODE_W-1:0] mode, input logic [LEN_W-1:0] len,
                         input logic [START_W-1:0] start, input logic [BYTE_W-1:0] rows);
    drain_results();
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_START, CFG_DATA_W'(start));
    write_reg(REG_ROW_BYTES, CFG_DATA_W'(rows));
    cfg_ch.valid <= 1'b0;
  endtask

  // Result side pacing: short random stalls, one long hold-off on request,
  // and none at all in quiet phases and near the end.
  initial begin : result_pacing
    int gap;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!calm && !quiet_phase && $urandom_range(0, 5) == 0) begin
        result_ch.ready <= 1'b0;
        gap = $urandom_range(1, 3);
        repeat (gap) @(negedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Ends the run when no channel has moved anything for too long.
  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                 n_events;
    int                 done;
    int                 k;
    int                 pick;
    int                 phases;
    logic [MODE_W-1:0]  job_mode;
    logic [LEN_W-1:0]   job_len;
    logic [START_W-1:0] job_start;
    logic [BYTE_W-1:0]  job_rows;
    logic [ADDR_W-1:0]  base;
    logic [ADDR_W-1:0]  a;

    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.kind         = KIND_LOAD;
    item_ch.load_address = '0;
    item_ch.load_data    = '0;
    item_ch.cts_busy     = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_MODE;
    cfg_ch.data          = '0;
    phases               = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Flow control from reset: nothing to send, busy stop, polls either way.
    send_item(KIND_TX_READY, '0, '0, 1'b0);
    send_item(KIND_CTS_POLL, '0, '0, 1'b0);
    send_item(KIND_TX_READY, '1, '1, 1'b1);
    send_item(KIND_CTS_POLL, '0, '0, 1'b1);
    send_item(KIND_CTS_POLL, '1, '1, 1'b0);
    send_item(KIND_LOAD, '0, 8'h00, 1'b0);
    send_item(KIND_LOAD, '1, 8'hff, 1'b0);
    send_item(KIND_LOAD, 10'd1, 8'ha5, 1'b1);

    // Block count that wraps the store address, then runs out.
    set_job(MODE_BLOCK, 11'd2, '1, 8'd1);
    phases++;
    send_event(KIND_START, 1'b0);
    repeat (4) send_event(KIND_TX_READY, 1'b0);

    // Raster with a zero row width: header carries 0 and the row runs past length.
    set_job(MODE_RASTER, 11'd1, '0, 8'd0);
    phases++;
    send_event(KIND_START, 1'b0);
    repeat (6) send_event(KIND_TX_READY, 1'b0);

    // The unused mode sends nothing.
    set_job(MODE_UNUSED, 11'd3, '0, 8'd1);
    phases++;
    send_event(KIND_START, 1'b0);
    send_event(KIND_TX_READY, 1'b0);

    // Random jobs: load the bytes the job can reach, start it, then feed events.
    calm_mark = items_sent + RANDOM_ITEMS - CALM_ITEMS;
    while (items_sent < calm_mark + CALM_ITEMS) begin
      pick     = $urandom_range(0, 11);
      job_mode = (pick == 11) ? MODE_UNUSED : MODE_W'($urandom_range(0, 2));
      pick     = $urandom_range(0, 7);
      job_len  = (pick == 0) ? '0 : (pick == 1) ? LEN_W'(STORE_DEPTH) :
                 (pick == 2) ? LEN_W'($urandom_range(0, STORE_DEPTH)) :
                 LEN_W'($urandom_range(1, 12));
      pick      = $urandom_range(0, 5);
      job_start = (pick == 0) ? '0 : (pick == 1) ? '1 :
                  START_W'($urandom_range(0, STORE_DEPTH - 1));
      pick      = $urandom_range(0, 7);
      job_rows  = (pick == 0) ? '0 : (pick == 1) ? '1 :
                  (pick == 2) ? BYTE_W'($urandom_range(1, 255)) : BYTE_W'($urandom_range(1, 4));
      if (phases == HOLD_PHASE + 3) n_events = LONG_HOLD;
      else if ($urandom_range(0, 5) == 0) n_events = $urandom_range(40, 70);
      else n_events = $urandom_range(6, 24);
      base = (job_mode == MODE_PLAIN) ? '0 : job_start;

      set_job(job_mode, job_len, job_start, job_rows);
      quiet_phase = ($urandom_range(0, 2) == 0);
      phases++;

      // Every store read the job can make stays inside written entries.
      for (k = 0; k < n_events; k++) begin
        a = base + ADDR_W'(k);
        if (!stored_addr[a] || $urandom_range(0, 4) == 0)
          send_item(KIND_LOAD, a, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      send_event(KIND_START, 1'($urandom_range(0, 1)));
      if (phases == HOLD_PHASE + 3) hold_off_req = 1'b1;

      done = 0;
      while (done < n_events) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          send_event(KIND_TX_READY, $urandom_range(0, 3) == 0);
          done++;
        end else if (pick < 16) begin
          send_event(KIND_CTS_POLL, $urandom_range(0, 2) == 0);
          done++;
        end else if (pick < 19) begin
          send_item(KIND_LOAD, ADDR_W'($urandom_range(0, STORE_DEPTH - 1)),
                    BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          send_event(KIND_START, 1'($urandom_range(0, 1)));
        end
      end
    end

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);

    $display("tb: %0d items over %0d job setups in all modes, %0d bytes handed out",
             items_sent, phases, bytes_framed);
    $display("tb: flow stops, CTS resumes, long result stall and row headers exercised");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
